### rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       last;
    } result_t;

endpackage

### rtl/wsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Header and payload walker: one received byte updates the frame state and
// yields at most one result item in the same cycle.
// ----------------------------------------------------------------------------
module wsd_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               byte_valid,
    input  logic [7:0]         byte_in,
    output logic               res_valid,
    output wsd_pkg::result_t   res
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;

    logic [15:0] max_payload_reg;
    logic [2:0]  phase_reg,    phase_next;
    logic [3:0]  opcode_reg,   opcode_next;
    logic [63:0] accum_reg,    accum_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] remain_reg,   remain_next;
    logic        dropping_reg, dropping_next;

    logic        hdr_done;
    logic [63:0] hdr_len;
    logic [63:0] remain_dec;
    logic [63:0] accum_shift;
    logic [3:0]  ext_left_dec;

    assign remain_dec   = remain_reg - 64'd1;
    assign accum_shift  = {accum_reg[55:0], byte_in};
    assign ext_left_dec = ext_left_reg - 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        accum_next    = accum_reg;
        ext_left_next = ext_left_reg;
        remain_next   = remain_reg;
        dropping_next = dropping_reg;
        hdr_done      = 1'b0;
        hdr_len       = 64'd0;
        res_valid     = 1'b0;
        res.kind         = wsd_pkg::KIND_DATA;
        res.data_byte    = 8'd0;
        res.frame_opcode = opcode_reg;
        res.last         = 1'b0;

        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (byte_in[6:0] == wsd_pkg::LEN_EXT16
                        || byte_in[6:0] == wsd_pkg::LEN_EXT64)
                    begin
                        ext_left_next = (byte_in[6:0] == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
                        accum_next    = 64'd0;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                        hdr_len  = {57'd0, byte_in[6:0]};
                    end
                end
                PH_EXT:
                begin
                    accum_next    = accum_shift;
                    ext_left_next = ext_left_dec;
                    if (ext_left_dec == 4'd0)
                    begin
                        hdr_done = 1'b1;
                        hdr_len  = accum_shift;
                    end
                end
                PH_BODY:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 64'd0)
                        phase_next = PH_HDR0;
                    if (dropping_reg)
                    begin
                        if (remain_dec == 64'd0)
                        begin
                            dropping_next = 1'b0;
                            res_valid     = 1'b1;
                            res.kind      = wsd_pkg::KIND_DROP;
                            res.last      = 1'b1;
                        end
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.kind      = wsd_pkg::KIND_DATA;
                        res.data_byte = byte_in;
                        res.last      = (remain_dec == 64'd0);
                    end
                end
                default:
                begin
                    opcode_next = byte_in[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            // header finished: start the payload walk or report an empty frame
            if (hdr_done)
            begin
                if (hdr_len == 64'd0)
                begin
                    phase_next    = PH_HDR0;
                    dropping_next = 1'b0;
                    remain_next   = 64'd0;
                    res_valid     = 1'b1;
                    res.kind      = wsd_pkg::KIND_EMPTY;
                    res.last      = 1'b1;
                end
                else
                begin
                    dropping_next = (hdr_len > {48'd0, max_payload_reg});
                    remain_next   = hdr_len;
                    phase_next    = PH_BODY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsd_pkg::MAX_PAYLOAD_RESET;
            phase_reg       <= PH_HDR0;
            opcode_reg      <= 4'd0;
            accum_reg       <= 64'd0;
            ext_left_reg    <= 4'd0;
            remain_reg      <= 64'd0;
            dropping_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_payload_reg <= cfg_wr_data;
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            accum_reg    <= accum_next;
            ext_left_reg <= ext_left_next;
            remain_reg   <= remain_next;
            dropping_reg <= dropping_next;
        end
    end

endmodule

### rtl/wsd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_skid
// Output register with one skid stage, so the parser keeps taking bytes
// while a finished result waits for the receiver.
// ----------------------------------------------------------------------------
module wsd_skid
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  wsd_pkg::result_t   push_data,
    output logic               space,
    output logic               out_valid,
    output wsd_pkg::result_t   out_data,
    input  logic               out_ready
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    wsd_pkg::result_t out_reg;
    wsd_pkg::result_t skid_reg;
    logic             out_take;

    assign out_take  = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (push_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (push_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule

### rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses unmasked websocket frames from a byte stream into payload items.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one received link byte per item in tdata.
//   m_axis carries results: tuser is the kind (payload byte, empty frame,
//   oversize frame dropped), tdata holds the payload byte and the frame
//   opcode, tlast marks the item that ends a frame.
//   header bytes give no result but for an empty frame, whose last header
//   byte gives one empty notice; a dropped frame gives only one drop notice, on its last byte.
//   cfg_wr_en / cfg_wr_data set the largest accepted payload length; it is
//   sampled when a frame header ends.
// timing
//   one input item per cycle while s_axis_tready is high; each result is
//   registered into the output register, or the skid stage if it is held.
//   the per-byte work is one 64-bit decrement and compare on the remaining length.
//   when the receiver stalls the output register holds and a one-entry skid
//   stage takes one more result; s_axis_tready then drops until it drains.
// reset
//   rst_n clears the parser to wait for a first header byte, empties the
//   output stages and sets the limit to 4096 bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] data_byte, [11:8] frame_opcode, rest zero
    output logic [1:0]  m_axis_tuser,    // [1:0] kind
    output logic        m_axis_tlast
);

    logic             in_accept;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t out_item;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    wsd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (in_accept),
        .byte_in     (s_axis_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsd_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res),
        .space      (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_item),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, out_item.frame_opcode, out_item.data_byte};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule

### rtl/wsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module wsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == wsd_pkg::KIND_DATA
            || m_axis_tuser == wsd_pkg::KIND_EMPTY
            || m_axis_tuser == wsd_pkg::KIND_DROP))
    else $error("illegal result kind");

    // empty and drop notices always end the frame and carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != wsd_pkg::KIND_DATA |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("notice without last or with data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
    else $error("tdata pad bits set");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches both streams of the websocket frame deframer, parses the accepted
// link bytes with its own frame parser, queues the results that the parser
// expects and compares every accepted output item against the oldest one.
// ----------------------------------------------------------------------------
module deframer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        WAIT_OPCODE = 3'd0,
        WAIT_LEN    = 3'd1,
        EXT_LEN     = 3'd2,
        PAYLOAD     = 3'd3
    } parse_phase_t;

    logic [15:0]      limit;
    parse_phase_t     phase;
    logic [3:0]       opcode;
    logic [63:0]      len_acc;
    logic [3:0]       ext_left;
    logic [63:0]      remaining;
    logic             dropping;

    wsd_pkg::result_t frame_results_q[$];
    wsd_pkg::result_t want;
    wsd_pkg::result_t got;
    wsd_pkg::result_t predicted;

    // header complete: an empty frame ends here, anything else enters payload
    function automatic bit close_header(input logic [63:0] len,
                                        output wsd_pkg::result_t r);
        bit has;
        r   = '0;
        has = 1'b0;
        if (len == 64'd0)
        begin
            phase     = WAIT_OPCODE;
            dropping  = 1'b0;
            remaining = 64'd0;
            r         = '{wsd_pkg::KIND_EMPTY, 8'h00, opcode, 1'b1};
            has       = 1'b1;
        end
        else
        begin
            dropping  = (len > {48'd0, limit});
            remaining = len;
            phase     = PAYLOAD;
        end
        return has;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output wsd_pkg::result_t r);
        bit   has;
        logic ends;
        r   = '0;
        has = 1'b0;
        case (phase)
            WAIT_LEN:
            begin
                if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    ext_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
                    len_acc  = 64'd0;
                    phase    = EXT_LEN;
                end
                else
                begin
                    has = close_header({57'd0, b[6:0]}, r);
                end
            end
            EXT_LEN:
            begin
                // extended length is big-endian
                len_acc  = {len_acc[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0)
                begin
                    has = close_header(len_acc, r);
                end
            end
            PAYLOAD:
            begin
                remaining = remaining - 64'd1;
                ends      = (remaining == 64'd0);
                if (ends)
                begin
                    phase = WAIT_OPCODE;
                end
                if (dropping)
                begin
                    if (ends)
                    begin
                        dropping = 1'b0;
                        r        = '{wsd_pkg::KIND_DROP, 8'h00, opcode, 1'b1};
                        has      = 1'b1;
                    end
                end
                else
                begin
                    r   = '{wsd_pkg::KIND_DATA, b, opcode, ends};
                    has = 1'b1;
                end
            end
            default:
            begin
                opcode = b[3:0];
                phase  = WAIT_LEN;
            end
        endcase
        return has;
    endfunction

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit     = wsd_pkg::MAX_PAYLOAD_RESET;
            phase     = WAIT_OPCODE;
            opcode    = 4'd0;
            len_acc   = 64'd0;
            ext_left  = 4'd0;
            remaining = 64'd0;
            dropping  = 1'b0;
            frame_results_q.delete();
            pending   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit = cfg_wr_data;
            end
            // the output is registered, so compare before predicting
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast};
                if (frame_results_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result kind=%0d data=%02h opcode=%0h last=%0b",
                             $time, got.kind, got.data_byte, got.frame_opcode, got.last);
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    if (got.kind != want.kind || got.data_byte != want.data_byte ||
                        got.frame_opcode != want.frame_opcode || got.last != want.last ||
                        m_axis_tdata[15:12] != 4'h0)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected kind=%0d data=%02h opcode=%0h last=%0b",
                                 $time, want.kind, want.data_byte, want.frame_opcode,
                                 want.last);
                        $display("%0t:          actual   kind=%0d tdata=%04h last=%0b",
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (parse_byte(s_axis_tdata, predicted))
                begin
                    frame_results_q.push_back(predicted);
                end
            end
            pending = frame_results_q.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the websocket frame deframer with framed link bytes: a few directed
// frames, then random frames under a range of payload limits, with bursty
// input, a stalling receiver and one long receiver hold-off. A checker beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          LIMIT_CYCLES   = 1000000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_AFTER     = 150;
    localparam int          PHASE_BYTES    = 44;
    localparam logic [63:0] LONG_FRAME_LEN = 64'd126;

    typedef enum logic [1:0] {
        FORM_SHORT = 2'd0,
        FORM_EXT16 = 2'd1,
        FORM_EXT64 = 2'd2
    } len_form_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [7:0] data_byte, [11:8] frame_opcode, rest zero
    logic [1:0]  m_axis_tuser;     // [1:0] kind
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          sent_count;
    int          burst_left;
    int          cycles;
    bit          held_off;

    websocket_frame_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    deframer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        m_axis_tready = 1'b0;
        sent_count    = 0;
        burst_left    = 0;
        cycles        = 0;
        held_off      = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // one link byte, in bursts of random length with random gaps between them
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [7:0] head, input logic [63:0] len,
                               input len_form_t form, input logic mask);
        push_byte(head);
        case (form)
            FORM_EXT16:
            begin
                push_byte({mask, wsd_pkg::LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            FORM_EXT64:
            begin
                push_byte({mask, wsd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                begin
                    push_byte(len[8*i +: 8]);
                end
            end
            default:
            begin
                push_byte({mask, len[6:0]});
            end
        endcase
    endtask

    task automatic send_payload(input longint count);
        for (longint n = 0; n < count; n++)
        begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_frame(input logic [7:0] head, input logic [63:0] len,
                              input len_form_t form, input logic mask);
        send_header(head, len, form, mask);
        send_payload(len);
    endtask

    // limit changes only once the parser has no result outstanding
    task automatic write_limit(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic random_frame(input logic [15:0] cap);
        logic [63:0] len;
        int          pick;
        len_form_t   form;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            len = 64'd0;
        end
        else if (pick < 65)
        begin
            len = 64'($urandom_range(1, 10));
        end
        else if (pick < 80)
        begin
            len = 64'($urandom_range(11, 40));
        end
        else if (pick < 85)
        begin
            len = 64'($urandom_range(100, 125));
        end
        else if (cap <= 16'd200)
        begin
            // right around the limit
            if (cap == 16'd0)
            begin
                len = 64'($urandom_range(0, 1));
            end
            else
            begin
                len = {48'd0, cap} - 64'd1 + 64'($urandom_range(0, 2));
            end
        end
        else
        begin
            len = 64'($urandom_range(1, 10));
        end
        if (len < 64'd126)
        begin
            pick = $urandom_range(0, 9);
            form = (pick < 6) ? FORM_SHORT : ((pick < 8) ? FORM_EXT16 : FORM_EXT64);
        end
        else
        begin
            form = ($urandom_range(0, 1) != 0) ? FORM_EXT16 : FORM_EXT64;
        end
        send_frame(8'($urandom_range(0, 255)), len, form, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input logic [15:0] cap);
        int start;
        write_limit(cap);
        start = sent_count;
        while (sent_count - start < PHASE_BYTES)
        begin
            random_frame(cap);
        end
    endtask

    // receiver: stretches of random ready density, plus one long hold-off
    initial
    begin
        int stretch;
        int ready_pct;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && sent_count >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                stretch = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 25;
                endcase
                repeat (stretch)
                begin
                    m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames under the reset limit; mask bit set must not matter
        send_frame(8'h81, 64'd0, FORM_SHORT, 1'b1);
        send_frame(8'h0F, 64'd1, FORM_SHORT, 1'b0);
        send_frame(8'h8A, 64'd0, FORM_EXT16, 1'b0);
        send_frame(8'hF0, 64'd2, FORM_EXT64, 1'b1);

        // limit raised while an oversize frame is in flight: still dropped
        write_limit(16'd5);
        send_header(8'h82, 64'd8, FORM_SHORT, 1'b0);
        send_payload(3);
        write_limit(16'd100);
        send_payload(5);
        send_frame(8'h82, 64'd8, FORM_SHORT, 1'b0);

        run_phase(16'd0);
        run_phase(16'hFFFF);
        send_frame(8'h82, LONG_FRAME_LEN, FORM_EXT16, 1'b0);
        run_phase(16'($urandom_range(1, 12)));
        run_phase(wsd_pkg::MAX_PAYLOAD_RESET);
        run_phase(16'($urandom_range(0, 65535)));

        // 64-bit length far above any limit: consumed silently, never ends
        send_header(8'($urandom_range(0, 255)),
                    {1'b1, 31'($urandom), 32'($urandom)}, FORM_EXT64, 1'b1);
        send_payload(16);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_skid.sv
rtl/websocket_frame_deframer.sv
rtl/wsd_checker.sv
tb/sv/deframer_checker.sv
tb/sv/testbench.sv
